// ===== hw/rtl/equirect_pixel_to_unit_vector_assert.svh =====
// Assertion macros used by the block's top-level RTL file.
`ifndef EQUIRECT_PIXEL_TO_UNIT_VECTOR_ASSERT_SVH
`define EQUIRECT_PIXEL_TO_UNIT_VECTOR_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define EPUV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the following cycle, checked during reset as well.
`define EPUV_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/epuv_pkg.sv =====
package epuv_pkg;

  localparam int IN_W = 18;
  localparam int CFG_W = 15;
  localparam int PHASE_W = 32;
  localparam int DP_FRAC = 30;
  localparam int DW = 33;
  localparam int ZW = 34;
  localparam int WIDTH_RESET = 4096;
  localparam int MIN_WIDTH = 2;

  localparam int DEF_POS_FRAC_BITS = 4;
  localparam int DEF_OUT_FRAC_BITS = 14;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_MAX_WIDTH = 16384;

  localparam logic signed [DW-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cordic_t;

  // Arctangent of 2^-i as a fraction of a turn, 2^32 to the turn.
  function automatic logic [PHASE_W-1:0] atan_turn(input logic [4:0] i);
    logic [PHASE_W-1:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/epuv_div_cell.sv =====
// One restoring division step: brings in one numerator bit, yields one quotient bit.
module epuv_div_cell import epuv_pkg::*; #(
  parameter int DEN_W = 20,
  parameter int NUM_W = 50
) (
  input  logic               clk,
  input  logic               en,
  input  logic [DEN_W-1:0]   den,
  input  logic [DEN_W-1:0]   rem_in,
  input  logic [NUM_W-1:0]   num_in,
  input  logic [PHASE_W-1:0] q_in,
  output logic [DEN_W-1:0]   rem,
  output logic [NUM_W-1:0]   num,
  output logic [PHASE_W-1:0] q
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial = {rem_in, num_in[NUM_W-1]};
    diff = trial - {1'b0, den};
    ge = trial >= {1'b0, den};
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      num <= {num_in[NUM_W-2:0], 1'b0};
      q <= {q_in[PHASE_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/epuv_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation, registered.
module epuv_cordic_cell import epuv_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t d_in,
  output cordic_t d_out
);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] ang;
  cordic_t              d_next;

  always_comb begin
    dx = d_in.y >>> IDX;
    dy = d_in.x >>> IDX;
    ang = signed'({{(ZW-PHASE_W){1'b0}}, atan_turn(5'(IDX))});
    d_next.flip = d_in.flip;
    if (!d_in.z[ZW-1]) begin
      d_next.x = d_in.x - dx;
      d_next.y = d_in.y + dy;
      d_next.z = d_in.z - ang;
    end else begin
      d_next.x = d_in.x + dx;
      d_next.y = d_in.y - dy;
      d_next.z = d_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// ===== hw/rtl/epuv_finish.sv =====
// Product of two CORDIC values, sign fix, rounding and clamp: three stages.
module epuv_finish import epuv_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [DW-1:0]           a,
  input  logic signed [DW-1:0]           b,
  input  logic                           neg,
  output logic signed [OUT_FRAC_BITS+1:0] result
);

  localparam int PW = 2 * DW;
  localparam int SH = 2 * DP_FRAC - OUT_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = signed'({{(PW-1){1'b0}}, 1'b1} << (SH - 1));
  localparam logic signed [PW-1:0] ONE = signed'({{(PW-1){1'b0}}, 1'b1} << OUT_FRAC_BITS);

  logic signed [PW-1:0] prod;
  logic                 prod_neg;
  logic signed [PW-1:0] fixed;
  logic signed [PW-1:0] rounded;
  logic signed [PW-1:0] clamped;

  always_comb begin
    rounded = (fixed + HALF) >>> SH;
    if (rounded > ONE) begin
      clamped = ONE;
    end else if (rounded < -ONE) begin
      clamped = -ONE;
    end else begin
      clamped = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
      prod_neg <= neg;
      fixed <= prod_neg ? -prod : prod;
      result <= clamped[OUT_FRAC_BITS+1:0];
    end
  end

endmodule

// ===== hw/rtl/equirect_pixel_to_unit_vector.sv =====
// Equirectangular pixel to unit vector. Each accepted word carries a column and a
// row position (unsigned, POS_FRAC_BITS fraction bits) and produces one word with
// the unit direction dir_x, dir_y, dir_z (signed, OUT_FRAC_BITS fraction bits,
// clamped to +-1.0). The block takes one word every clock while in_stall is low
// and returns results in order through a long-division chain with one cell per
// numerator bit that turns a position into a turn phase, one CORDIC cell per
// stage, and product, sign and rounding stages. A word that meets out_stall at the
// output moves into a one-word holding register; while that register is full the
// pipeline holds and in_stall is high, so in_stall never follows out_stall in the
// same cycle. image_width is clamped to [2, MAX_WIDTH] and must be written only
// while idle.
module equirect_pixel_to_unit_vector import epuv_pkg::*; #(
  parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS,
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            image_width_we,
  input  logic [CFG_W-1:0]                image_width_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [IN_W-1:0]                 pixel_col,
  input  logic [IN_W-1:0]                 pixel_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [OUT_FRAC_BITS+1:0] dir_x,
  output logic signed [OUT_FRAC_BITS+1:0] dir_y,
  output logic signed [OUT_FRAC_BITS+1:0] dir_z
);

  `include "equirect_pixel_to_unit_vector_assert.svh"

  // Width and denominator sizing. The denominator is the width in position units.
  localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
  localparam int DEN_W = WID_BITS + POS_FRAC_BITS;
  localparam int NUM_W = IN_W + PHASE_W;
  localparam int LAT = NUM_W + CORDIC_STAGES + 3;
  localparam int CMP_W = (WID_BITS > CFG_W) ? WID_BITS : CFG_W;

  logic [CFG_W-1:0]    image_width;
  logic [WID_BITS-1:0] width_eff;
  logic [DEN_W-1:0]    den;
  logic                en;
  logic [LAT-1:0]      valid_pipe;
  logic                core_valid;
  logic                hold_valid;
  logic signed [OUT_FRAC_BITS+1:0] core_x;
  logic signed [OUT_FRAC_BITS+1:0] core_y;
  logic signed [OUT_FRAC_BITS+1:0] core_z;
  logic signed [OUT_FRAC_BITS+1:0] hold_x;
  logic signed [OUT_FRAC_BITS+1:0] hold_y;
  logic signed [OUT_FRAC_BITS+1:0] hold_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= CFG_W'(WIDTH_RESET);
    end else if (image_width_we) begin
      image_width <= image_width_wdata;
    end
  end

  // Narrow widths become 2 and wide ones MAX_WIDTH.
  always_comb begin
    if (CMP_W'(image_width) < CMP_W'(MIN_WIDTH)) begin
      width_eff = WID_BITS'(MIN_WIDTH);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      width_eff = WID_BITS'(MAX_WIDTH);
    end else begin
      width_eff = WID_BITS'(image_width);
    end
  end

  // The user must write the register only while idle (not enforced), so all division
  // cells can share this denominator; a word accepted right after a write sees it.
  assign den = DEN_W'(width_eff) << POS_FRAC_BITS;

  // The pipeline moves unless the holding register is full.
  assign en = !hold_valid;
  assign in_stall = hold_valid;
  assign core_valid = valid_pipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[LAT-2:0], in_valid};
    end
  end

  // Phase = round(pos * 2^32 / den) modulo one turn. The numerator is pos followed
  // by 32 bits of den/2; the chain keeps only the low 32 quotient bits, which is the
  // wrap around the circle for positions past the image.
  logic [DEN_W-1:0]   crem [0:NUM_W];
  logic [NUM_W-1:0]   cnum [0:NUM_W];
  logic [PHASE_W-1:0] cq   [0:NUM_W];
  logic [DEN_W-1:0]   rrem [0:NUM_W];
  logic [NUM_W-1:0]   rnum [0:NUM_W];
  logic [PHASE_W-1:0] rq   [0:NUM_W];
  logic [PHASE_W-1:0] half_den;

  assign half_den = PHASE_W'(den >> 1);
  assign crem[0] = '0;
  assign cnum[0] = {pixel_col, half_den};
  assign cq[0] = '0;
  assign rrem[0] = '0;
  assign rnum[0] = {pixel_row, half_den};
  assign rq[0] = '0;

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    epuv_div_cell #(.DEN_W(DEN_W), .NUM_W(NUM_W)) u_col (
      .clk(clk), .en(en), .den(den),
      .rem_in(crem[i]), .num_in(cnum[i]), .q_in(cq[i]),
      .rem(crem[i+1]), .num(cnum[i+1]), .q(cq[i+1])
    );
    epuv_div_cell #(.DEN_W(DEN_W), .NUM_W(NUM_W)) u_row (
      .clk(clk), .en(en), .den(den),
      .rem_in(rrem[i]), .num_in(rnum[i]), .q_in(rq[i]),
      .rem(rrem[i+1]), .num(rnum[i+1]), .q(rq[i+1])
    );
  end

  // Longitude starts half a turn back, latitude a quarter turn. Angles in the back
  // half of the circle are turned by half a turn and the result negated at the end.
  logic [PHASE_W-1:0] lon_ph;
  logic [PHASE_W-1:0] lat_ph;
  logic [PHASE_W-1:0] lon_q;
  logic [PHASE_W-1:0] lat_q;
  cordic_t            lon_c [0:CORDIC_STAGES];
  cordic_t            lat_c [0:CORDIC_STAGES];

  always_comb begin
    lon_ph = cq[NUM_W] - 32'h8000_0000;
    lat_ph = rq[NUM_W] - 32'h4000_0000;
    lon_q = lon_ph + 32'h4000_0000;
    lat_q = lat_ph + 32'h4000_0000;
    lon_c[0].flip = lon_q[PHASE_W-1];
    lat_c[0].flip = lat_q[PHASE_W-1];
    lon_c[0].x = CORDIC_GAIN;
    lat_c[0].x = CORDIC_GAIN;
    lon_c[0].y = '0;
    lat_c[0].y = '0;
    lon_c[0].z = ZW'(signed'(lon_q[PHASE_W-1] ? lon_ph + 32'h8000_0000 : lon_ph));
    lat_c[0].z = ZW'(signed'(lat_q[PHASE_W-1] ? lat_ph + 32'h8000_0000 : lat_ph));
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    epuv_cordic_cell #(.IDX(i)) u_lon (
      .clk(clk), .en(en), .d_in(lon_c[i]), .d_out(lon_c[i+1])
    );
    epuv_cordic_cell #(.IDX(i)) u_lat (
      .clk(clk), .en(en), .d_in(lat_c[i]), .d_out(lat_c[i+1])
    );
  end

  // The folded half-turn is applied as a sign on each product.
  localparam logic signed [DW-1:0] DP_ONE = signed'({{(DW-1){1'b0}}, 1'b1} << DP_FRAC);

  cordic_t lon_f;
  cordic_t lat_f;

  assign lon_f = lon_c[CORDIC_STAGES];
  assign lat_f = lat_c[CORDIC_STAGES];

  epuv_finish #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fin_x (
    .clk(clk), .en(en), .a(lat_f.x), .b(lon_f.y),
    .neg(lat_f.flip ^ lon_f.flip), .result(core_x)
  );

  epuv_finish #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fin_y (
    .clk(clk), .en(en), .a(lat_f.y), .b(DP_ONE),
    .neg(lat_f.flip), .result(core_y)
  );

  epuv_finish #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fin_z (
    .clk(clk), .en(en), .a(lat_f.x), .b(lon_f.x),
    .neg(lat_f.flip ^ lon_f.flip), .result(core_z)
  );

  // The holding register takes the pipeline's last word when it meets a stall and
  // gives it back once the receiver accepts it. Until then the pipeline holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!hold_valid && core_valid && out_stall) begin
      hold_valid <= 1'b1;
    end else if (hold_valid && !out_stall) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_valid) begin
      hold_x <= core_x;
      hold_y <= core_y;
      hold_z <= core_z;
    end
  end

  assign out_valid = hold_valid || core_valid;
  assign dir_x = hold_valid ? hold_x : core_x;
  assign dir_y = hold_valid ? hold_y : core_y;
  assign dir_z = hold_valid ? hold_z : core_z;

  localparam logic signed [OUT_FRAC_BITS+1:0] OUT_ONE =
    signed'({{(OUT_FRAC_BITS+1){1'b0}}, 1'b1} << OUT_FRAC_BITS);

  `EPUV_ASSERT_NEXT(a_reset_clears_out, clk, rst, !out_valid)
  `EPUV_ASSERT_NEXT(a_stall_keeps_word, clk, !rst && out_valid && out_stall, out_valid && $stable(dir_x))
  `EPUV_ASSERT_IMPL(a_y_in_range, clk, rst, out_valid, dir_y <= OUT_ONE && dir_y >= -OUT_ONE)
  `EPUV_ASSERT_IMPL(a_x_in_range, clk, rst, out_valid, dir_x <= OUT_ONE && dir_x >= -OUT_ONE)

endmodule
